/* rtl/blte_pkg.sv */
package blte_pkg;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] item_value;
      logic [4:0]         repeat_count;
      logic [2:0]         status;
      logic               last;
   } rsp_type;

   localparam logic [2:0] FUNC_APPEND = 3'd0;
   localparam logic [2:0] FUNC_INSERT = 3'd1;
   localparam logic [2:0] FUNC_REMOVE = 3'd2;
   localparam logic [2:0] FUNC_DEDUP  = 3'd3;
   localparam logic [2:0] FUNC_REPORT = 3'd4;
   localparam logic [2:0] FUNC_DUMP   = 3'd5;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
   localparam logic [2:0] ST_FULL       = 3'd2;
   localparam logic [2:0] ST_NO_REPEATS = 3'd3;
   localparam logic [2:0] ST_EMPTY      = 3'd4;

   localparam int MAX_RES = 16;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SEARCH,
      S_SHIFT_UP,
      S_SHIFT_DOWN,
      S_OUTER,
      S_INNER,
      S_REPORT_OUT,
      S_DUMP,
      S_DONE,
      S_WAIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic set_i_zero;
      logic inc_i;
      logic set_j_next;
      logic inc_j;
      logic set_k_cnt;
      logic set_k_from_i;
      logic set_k_from_j;
      logic inc_k;
      logic dec_k;
      logic write_at_k;
      logic write_at_cnt;
      logic copy_k_from_prev;
      logic copy_k_from_next;
      logic cnt_inc;
      logic cnt_dec;
      logic clr_rep;
      logic inc_rep;
      logic hold_load;
      logic emit;
      logic emit_last;
      logic [2:0] emit_status;
      logic emit_value;
      logic emit_hold;
      logic inc_nres;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] func;
      logic       empty;
      logic       full;
      logic       i_end;
      logic       i_last;
      logic       j_end;
      logic       k_gt_i;
      logic       k_last;
      logic       less_i;
      logic       eq_i;
      logic       eq_ij;
      logic       rep_pos;
      logic       res_full;
      logic       res_last;
      logic       nres_zero;
      logic       out_busy;
   } sts_type;

endpackage

/* rtl/blte_datapath.sv */
module blte_datapath #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  blte_pkg::req_type  req_data,
   input  blte_pkg::cmd_type  cmd,
   output blte_pkg::sts_type  sts,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output blte_pkg::rsp_type  rsp_data
);
   import blte_pkg::*;

   localparam int IW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam int NW = $clog2(MAX_RES + 1);

   logic signed [31:0] mem [DEPTH];

   req_type         req_ff;
   logic [IW-1:0]   cnt_ff, cnt_in;
   logic [IW-1:0]   i_ff, i_in;
   logic [IW-1:0]   j_ff, j_in;
   logic [IW-1:0]   k_ff, k_in;
   logic [5:0]      rep_ff, rep_in;
   logic [NW-1:0]   nres_ff, nres_in;
   logic signed [31:0] hval_ff, hval_in;
   logic [4:0]      hrep_ff, hrep_in;
   logic            ov_ff, ov_in;
   rsp_type         out_ff, out_in;

   logic signed [31:0] ent_i, ent_j, ent_kp, ent_kn;
   logic [AW-1:0]      ai, aj, ak, akp, akn, acnt;

   // register-array list: reads are at counter positions, small depth
   assign ai   = i_ff[AW-1:0];
   assign aj   = j_ff[AW-1:0];
   assign ak   = k_ff[AW-1:0];
   assign akp  = AW'(k_ff - IW'(1));
   assign akn  = AW'(k_ff + IW'(1));
   assign acnt = cnt_ff[AW-1:0];
   assign ent_i  = mem[ai];
   assign ent_j  = mem[aj];
   assign ent_kp = mem[akp];
   assign ent_kn = mem[akn];

   // k is the write pointer of the shifts
   always_ff @(posedge clock) begin
      if (cmd.write_at_cnt) begin
         mem[acnt] <= req_ff.value;
      end else if (cmd.write_at_k) begin
         mem[ak] <= req_ff.value;
      end else if (cmd.copy_k_from_prev) begin
         mem[ak] <= ent_kp;
      end else if (cmd.copy_k_from_next) begin
         mem[ak] <= ent_kn;
      end
   end

   always_comb begin
      i_in = i_ff;
      if (cmd.set_i_zero)        i_in = '0;
      else if (cmd.inc_i)        i_in = i_ff + IW'(1);
      j_in = j_ff;
      if (cmd.set_j_next)        j_in = i_ff + IW'(1);
      else if (cmd.inc_j)        j_in = j_ff + IW'(1);
      k_in = k_ff;
      if (cmd.set_k_cnt)         k_in = cnt_ff;
      else if (cmd.set_k_from_i) k_in = i_ff;
      else if (cmd.set_k_from_j) k_in = j_ff;
      else if (cmd.inc_k)        k_in = k_ff + IW'(1);
      else if (cmd.dec_k)        k_in = k_ff - IW'(1);
      cnt_in = cnt_ff;
      if (cmd.cnt_inc)           cnt_in = cnt_ff + IW'(1);
      else if (cmd.cnt_dec)      cnt_in = cnt_ff - IW'(1);
      rep_in = rep_ff;
      if (cmd.clr_rep)           rep_in = 6'd1;
      else if (cmd.inc_rep && rep_ff != 6'd63) rep_in = rep_ff + 6'd1;
      nres_in = nres_ff;
      if (cmd.load_req)          nres_in = '0;
      else if (cmd.inc_nres)     nres_in = nres_ff + NW'(1);
      // report result held back until it is known whether it is the final one
      hval_in = hval_ff;
      hrep_in = hrep_ff;
      if (cmd.hold_load) begin
         hval_in = ent_i;
         hrep_in = (rep_ff > 6'd31) ? 5'd31 : rep_ff[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req_data;
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      rep_ff  <= rep_in;
      hval_ff <= hval_in;
      hrep_ff <= hrep_in;
      if (reset) begin
         cnt_ff  <= '0;
         nres_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         nres_ff <= nres_in;
      end
   end

   // output register
   always_comb begin
      ov_in  = ov_ff;
      out_in = out_ff;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      if (cmd.emit) begin
         ov_in = 1'b1;
         out_in.item_value   = cmd.emit_hold ? hval_ff :
                               (cmd.emit_value ? ent_i : 32'sd0);
         out_in.repeat_count = cmd.emit_hold ? hrep_ff : 5'd0;
         out_in.status       = cmd.emit_status;
         out_in.last         = cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else       ov_ff <= ov_in;
      out_ff <= out_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

   assign sts.func      = req_ff.func;
   assign sts.empty     = (cnt_ff == '0);
   assign sts.full      = (cnt_ff >= IW'(DEPTH));
   assign sts.i_end     = (i_ff >= cnt_ff);
   assign sts.i_last    = ((i_ff + IW'(1)) >= cnt_ff);
   assign sts.j_end     = (j_ff >= cnt_ff);
   assign sts.k_gt_i    = (k_ff > i_ff);
   assign sts.k_last    = ((k_ff + IW'(1)) >= cnt_ff);
   assign sts.less_i    = (ent_i < req_ff.value);
   assign sts.eq_i      = (ent_i == req_ff.value);
   assign sts.eq_ij     = (ent_i == ent_j);
   assign sts.rep_pos   = (rep_ff > 6'd1);
   assign sts.res_full  = (nres_ff >= NW'(MAX_RES));
   assign sts.res_last  = ((nres_ff + NW'(1)) >= NW'(MAX_RES));
   assign sts.nres_zero = (nres_ff == '0);
   assign sts.out_busy  = ov_ff && !rsp_ready;

endmodule

/* rtl/blte_ctrl.sv */
module blte_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  blte_pkg::sts_type sts,
   output blte_pkg::cmd_type cmd
);
   import blte_pkg::*;

   state_type state_ff, state_in;
   // set when the shift belongs to a dedup pass and returns to the inner loop
   logic      ret_ff, ret_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_DISPATCH;
         S_DISPATCH: begin
            if (!sts.out_busy) begin
               unique case (sts.func)
                  FUNC_APPEND: state_in = S_WAIT;
                  FUNC_INSERT: state_in = sts.full ? S_WAIT : S_SEARCH;
                  FUNC_REMOVE: state_in = sts.empty ? S_WAIT : S_SEARCH;
                  FUNC_DEDUP:  state_in = S_OUTER;
                  FUNC_REPORT: state_in = S_OUTER;
                  FUNC_DUMP:   state_in = sts.empty ? S_WAIT : S_DUMP;
                  default:     state_in = S_WAIT;
               endcase
            end
         end
         S_SEARCH: begin
            if (sts.func == FUNC_INSERT) begin
               if (sts.i_end || !sts.less_i) state_in = S_SHIFT_UP;
            end else if (sts.i_end) begin
               state_in = S_DONE;
            end else if (sts.eq_i) begin
               ret_in   = 1'b0;
               state_in = S_SHIFT_DOWN;
            end
         end
         S_SHIFT_UP: if (!sts.k_gt_i) state_in = S_DONE;
         S_SHIFT_DOWN: begin
            if (sts.k_last) begin
               if (ret_ff) state_in = S_INNER;
               else if (!sts.out_busy) state_in = S_WAIT;
            end
         end
         S_OUTER: begin
            if (sts.i_end || (sts.func == FUNC_REPORT && sts.res_full)) state_in = S_DONE;
            else state_in = S_INNER;
         end
         S_INNER: begin
            if (sts.j_end) begin
               state_in = (sts.func == FUNC_REPORT) ? S_REPORT_OUT : S_OUTER;
            end else if (sts.eq_ij && sts.func == FUNC_DEDUP) begin
               ret_in   = 1'b1;
               state_in = S_SHIFT_DOWN;
            end
         end
         S_REPORT_OUT: begin
            if (!(sts.rep_pos && !sts.nres_zero && sts.out_busy)) state_in = S_OUTER;
         end
         S_DUMP: if (!sts.out_busy && (sts.i_end || sts.res_full)) state_in = S_WAIT;
         S_DONE: if (!sts.out_busy) state_in = S_WAIT;
         S_WAIT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: if (req_valid) cmd.load_req = 1'b1;
         S_DISPATCH: begin
            if (!sts.out_busy) begin
               cmd.set_i_zero = 1'b1;
               unique case (sts.func)
                  FUNC_APPEND: begin
                     cmd.emit = 1'b1;
                     cmd.emit_last = 1'b1;
                     if (sts.full) begin
                        cmd.emit_status = ST_FULL;
                     end else begin
                        cmd.emit_status = ST_OK;
                        cmd.write_at_cnt = 1'b1;
                        cmd.cnt_inc = 1'b1;
                     end
                  end
                  FUNC_INSERT: if (sts.full) begin
                     cmd.emit = 1'b1; cmd.emit_last = 1'b1; cmd.emit_status = ST_FULL;
                  end
                  FUNC_REMOVE: if (sts.empty) begin
                     cmd.emit = 1'b1; cmd.emit_last = 1'b1; cmd.emit_status = ST_EMPTY;
                  end
                  FUNC_DEDUP, FUNC_REPORT: ;
                  FUNC_DUMP: if (sts.empty) begin
                     cmd.emit = 1'b1; cmd.emit_last = 1'b1; cmd.emit_status = ST_EMPTY;
                  end
                  default: begin
                     cmd.emit = 1'b1; cmd.emit_last = 1'b1; cmd.emit_status = ST_OK;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (sts.func == FUNC_INSERT) begin
               if (sts.i_end || !sts.less_i) cmd.set_k_cnt = 1'b1;
               else cmd.inc_i = 1'b1;
            end else if (!sts.i_end) begin
               if (sts.eq_i) begin
                  cmd.set_k_from_i = 1'b1;
               end else begin
                  cmd.inc_i = 1'b1;
               end
            end
         end
         S_SHIFT_UP: begin
            // i holds the insert position, k walks down from the tail
            if (sts.k_gt_i) begin
               cmd.copy_k_from_prev = 1'b1;
               cmd.dec_k = 1'b1;
            end else begin
               cmd.write_at_k = 1'b1;
               cmd.cnt_inc = 1'b1;
            end
         end
         S_SHIFT_DOWN: begin
            // k walks up from the removed slot
            if (!sts.k_last) begin
               cmd.copy_k_from_next = 1'b1;
               cmd.inc_k = 1'b1;
            end else if (ret_ff) begin
               cmd.cnt_dec = 1'b1;
            end else if (!sts.out_busy) begin
               cmd.cnt_dec = 1'b1;
               cmd.emit = 1'b1;
               cmd.emit_last = 1'b1;
               cmd.emit_status = ST_OK;
            end
         end
         S_OUTER: if (!(sts.i_end || (sts.func == FUNC_REPORT && sts.res_full))) begin
            cmd.set_j_next = 1'b1;
            cmd.clr_rep = 1'b1;
         end
         S_INNER: begin
            if (!sts.j_end) begin
               if (sts.eq_ij && sts.func == FUNC_DEDUP) begin
                  // drop the duplicate at j, the scan resumes at the same j
                  cmd.set_k_from_j = 1'b1;
               end else begin
                  if (sts.eq_ij) cmd.inc_rep = 1'b1;
                  cmd.inc_j = 1'b1;
               end
            end else if (sts.func == FUNC_DEDUP) begin
               cmd.inc_i = 1'b1;
            end
         end
         S_REPORT_OUT: begin
            if (sts.rep_pos) begin
               if (sts.nres_zero) begin
                  cmd.hold_load = 1'b1;
                  cmd.inc_nres = 1'b1;
                  cmd.inc_i = 1'b1;
               end else if (!sts.out_busy) begin
                  // a newer result exists, so the held one is not the final one
                  cmd.emit = 1'b1;
                  cmd.emit_hold = 1'b1;
                  cmd.emit_status = ST_OK;
                  cmd.hold_load = 1'b1;
                  cmd.inc_nres = 1'b1;
                  cmd.inc_i = 1'b1;
               end
            end else begin
               cmd.inc_i = 1'b1;
            end
         end
         S_DUMP: if (!sts.out_busy && !(sts.i_end || sts.res_full)) begin
            cmd.emit = 1'b1;
            cmd.emit_value = 1'b1;
            cmd.emit_status = ST_OK;
            cmd.emit_last = sts.i_last || sts.res_last;
            cmd.inc_nres = 1'b1;
            cmd.inc_i = 1'b1;
         end
         S_DONE: if (!sts.out_busy) begin
            cmd.emit = 1'b1;
            cmd.emit_last = 1'b1;
            unique case (sts.func)
               FUNC_REMOVE: cmd.emit_status = ST_NOT_FOUND;
               FUNC_REPORT: cmd.emit_status = sts.nres_zero ? ST_NO_REPEATS : ST_OK;
               default:     cmd.emit_status = ST_OK;
            endcase
            if (sts.func == FUNC_REPORT && !sts.nres_zero) cmd.emit_hold = 1'b1;
         end
         default: ;
      endcase
   end

endmodule

/* rtl/bounded_list_table_engine_unit.sv */
// channel | dir | handshake             | payload
// req     | in  | req_valid / req_ready | req_data (func, value)
// rsp     | out | rsp_valid / rsp_ready | rsp_data (item_value, repeat_count, status, last)
// one request at a time; the list walk covers one entry per cycle unless a stalled rsp
// holds it at an emit point (dedup walks all pairs)
// reset clears the entry count and the controller; the list storage is not cleared
// a stalled rsp holds the walk at the next emit point
module bounded_list_table_engine_unit #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  blte_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output blte_pkg::rsp_type rsp_data
);
   import blte_pkg::*;

   cmd_type cmd;
   sts_type sts;

   blte_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .sts, .cmd
   );

   blte_datapath #(.DEPTH(DEPTH)) u_dp (
      .clock, .reset, .req_data, .cmd, .sts, .rsp_valid, .rsp_ready, .rsp_data
   );

`ifndef SYNTH
   a_no_req_when_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("double accept");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last |=> !req_ready)
      else $error("request ended without last");
`endif

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import blte_pkg::*;

   localparam int LIST_DEPTH = 16;
   localparam logic [2:0] FUNC_UNUSED6 = 3'd6;
   localparam logic [2:0] FUNC_UNUSED7 = 3'd7;
   localparam int CYCLE_LIMIT = 5000000;
   localparam int DRAIN_CYCLES = 2 * LIST_DEPTH * LIST_DEPTH + 20;

   // list model plus queue of predicted responses
   class list_scoreboard;
      logic signed [31:0] list_vals[$];
      rsp_type pending[$];
      int mismatches;

      function void push_single(logic [2:0] st);
         rsp_type r;
         r = '0;
         r.status = st;
         r.last = 1'b1;
         pending.push_back(r);
      endfunction

      function void note_request(req_type req);
         int pos;
         int cnt;
         int nres;
         rsp_type r;
         case (req.func)
            FUNC_APPEND: begin
               if (list_vals.size() >= LIST_DEPTH) push_single(ST_FULL);
               else begin
                  list_vals.push_back(req.value);
                  push_single(ST_OK);
               end
            end
            FUNC_INSERT: begin
               if (list_vals.size() >= LIST_DEPTH) push_single(ST_FULL);
               else begin
                  pos = 0;
                  while (pos < list_vals.size() && list_vals[pos] < req.value) pos++;
                  list_vals.insert(pos, req.value);
                  push_single(ST_OK);
               end
            end
            FUNC_REMOVE: begin
               if (list_vals.size() == 0) push_single(ST_EMPTY);
               else begin
                  pos = 0;
                  while (pos < list_vals.size() && list_vals[pos] != req.value) pos++;
                  if (pos == list_vals.size()) push_single(ST_NOT_FOUND);
                  else begin
                     list_vals.delete(pos);
                     push_single(ST_OK);
                  end
               end
            end
            FUNC_DEDUP: begin
               for (int i = 0; i < list_vals.size(); i++) begin
                  int j;
                  j = i + 1;
                  while (j < list_vals.size()) begin
                     if (list_vals[j] == list_vals[i]) list_vals.delete(j);
                     else j++;
                  end
               end
               push_single(ST_OK);
            end
            FUNC_REPORT: begin
               nres = 0;
               for (int i = 0; i < list_vals.size() && nres < MAX_RES; i++) begin
                  cnt = 0;
                  for (int j = i + 1; j < list_vals.size(); j++)
                     if (list_vals[j] == list_vals[i]) cnt++;
                  if (cnt > 0) begin
                     r = '0;
                     r.item_value = list_vals[i];
                     r.repeat_count = (cnt + 1 > 31) ? 5'd31 : 5'(cnt + 1);
                     r.status = ST_OK;
                     pending.push_back(r);
                     nres++;
                  end
               end
               if (nres == 0) push_single(ST_NO_REPEATS);
               else pending[pending.size() - 1].last = 1'b1;
            end
            FUNC_DUMP: begin
               if (list_vals.size() == 0) push_single(ST_EMPTY);
               else begin
                  for (int i = 0; i < list_vals.size() && i < MAX_RES; i++) begin
                     r = '0;
                     r.item_value = list_vals[i];
                     r.status = ST_OK;
                     pending.push_back(r);
                  end
                  pending[pending.size() - 1].last = 1'b1;
               end
            end
            default: push_single(ST_OK);
         endcase
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response %p", got);
            return;
         end
         want = pending.pop_front();
         if (got.item_value !== want.item_value || got.repeat_count !== want.repeat_count
             || got.status !== want.status || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %p, got %p", want, got);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;

   list_scoreboard board = new();
   int cycles = 0;
   bit hold_rsp = 1'b0;
   bit stim_done = 1'b0;
   logic signed [31:0] value_pool[8];

   always #6 clock = ~clock;

   bounded_list_table_engine_unit #(.DEPTH(LIST_DEPTH)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
      if (!reset && req_valid && req_ready) board.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_data);
   end

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // receiver side: random stalls, plus a long hold when asked
   initial begin : rsp_side
      int n;
      @(negedge clock);
      while (1) begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            for (int i = 0; i < 600; i++) @(negedge clock);
            hold_rsp = 1'b0;
         end
         n = stim_done ? 0 : gap_len();
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
      end
   end

   // valid stays high into the next request when there is no gap
   task automatic send_request(logic [2:0] func, logic signed [31:0] value);
      int n;
      n = gap_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{func: func, value: value};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 3))
         0: return $urandom();
         default: return value_pool[$urandom_range(0, 7)];
      endcase
   endfunction

   initial begin : stimulus
      logic [2:0] f;
      int pick;
      foreach (value_pool[k]) value_pool[k] = $urandom();
      value_pool[0] = 32'sh8000_0000;
      value_pool[1] = 32'sh7fff_ffff;
      value_pool[2] = 0;
      value_pool[3] = -1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty-list cases, then fill to full, duplicates, extremes
      send_request(FUNC_DUMP, 0);
      send_request(FUNC_REMOVE, 5);
      send_request(FUNC_REPORT, 0);
      send_request(FUNC_INSERT, 32'sh7fff_ffff);
      send_request(FUNC_INSERT, 32'sh8000_0000);
      send_request(FUNC_INSERT, 0);
      send_request(FUNC_APPEND, -1);
      send_request(FUNC_APPEND, 0);
      send_request(FUNC_REMOVE, 12345);
      send_request(FUNC_REPORT, 0);
      for (int i = 0; i < 11; i++) send_request(FUNC_APPEND, (i % 2) ? 32'sh8000_0000 : 7);
      send_request(FUNC_INSERT, 3);
      send_request(FUNC_APPEND, 3);
      send_request(FUNC_REPORT, 0);
      send_request(FUNC_DUMP, 0);
      send_request(FUNC_DEDUP, 0);
      send_request(FUNC_DUMP, 0);
      send_request(FUNC_UNUSED6, 0);
      send_request(FUNC_UNUSED7, -1);
      send_request(FUNC_REMOVE, 32'sh7fff_ffff);
      send_request(FUNC_REMOVE, 32'sh8000_0000);

      // pause until everything is drained
      wait_drained();
      hold_rsp = 1'b1;

      for (int n = 0; n < 360; n++) begin
         if (n == 180) wait_drained();
         pick = $urandom_range(0, 99);
         if (pick < 25) f = FUNC_APPEND;
         else if (pick < 50) f = FUNC_INSERT;
         else if (pick < 70) f = FUNC_REMOVE;
         else if (pick < 76) f = FUNC_DEDUP;
         else if (pick < 86) f = FUNC_REPORT;
         else if (pick < 96) f = FUNC_DUMP;
         else f = ($urandom_range(0, 1) == 0) ? FUNC_UNUSED6 : FUNC_UNUSED7;
         send_request(f, pick_value());
      end

      stim_done = 1'b1;
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule

/* files.f */
rtl/blte_pkg.sv
rtl/blte_datapath.sv
rtl/blte_ctrl.sv
rtl/bounded_list_table_engine_unit.sv
dv/tb_top.sv
